### hw/rtl/tcp_pkg.sv
// Texture container parser: shared types and constants.
// Record layout carried from the parse front to the output back end.
// No dependencies.
package tcp_pkg;

  // Result record kinds
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_DURATION = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  // Status / error codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_LENGTH   = 4'd1;
  localparam logic [3:0] ST_MAGIC    = 4'd2;
  localparam logic [3:0] ST_VERSION  = 4'd3;
  localparam logic [3:0] ST_FORMAT   = 4'd4;
  localparam logic [3:0] ST_DIMS     = 4'd5;
  localparam logic [3:0] ST_FRAMES   = 4'd6;
  localparam logic [3:0] ST_DURATION = 4'd7;
  localparam logic [3:0] ST_PAYSIZE  = 4'd8;

  // Container constants
  localparam logic [31:0] MAGIC_WORD      = 32'h3153_544C;
  localparam logic [15:0] MAX_DIMENSION   = 16'd4096;
  localparam logic [15:0] MAX_FRAMES      = 16'd256;
  localparam logic [5:0]  HEADER_V1_BYTES = 6'd24;
  localparam logic [5:0]  HEADER_V2_BYTES = 6'd36;
  localparam logic [15:0] VERSION_ONE     = 16'd1;
  localparam logic [15:0] CURRENT_VERSION = 16'd2;
  localparam logic [15:0] FMT_ALBEDO      = 16'd1;
  localparam logic [15:0] FMT_NORMALS     = 16'd2;

  // Header byte offsets (little-endian fields)
  localparam int OFF_MAGIC  = 0;
  localparam int OFF_VER    = 4;
  localparam int OFF_HSIZE  = 6;
  localparam int OFF_WIDTH  = 8;
  localparam int OFF_HEIGHT = 10;
  localparam int OFF_FRAMES = 12;
  localparam int OFF_MS     = 14;
  localparam int OFF_FMT    = 16;
  localparam int OFF_RES    = 18;
  localparam int OFF_PAY    = 20;
  localparam int OFF_STIME  = 24;
  localparam int OFF_SSIZE  = 32;

  // One result record as queued between front and back
  typedef struct packed {
    kind_t       kind;
    logic [12:0] width;
    logic [12:0] height;
    logic [8:0]  frames;
    logic        with_normals;
    logic [1:0]  version;
    logic [63:0] source_time;
    logic [31:0] source_size;
    logic [15:0] duration;
    logic [7:0]  texel;
    logic        normal_plane;
    logic [3:0]  status;
  } rec_t;

endpackage

### hw/rtl/texture_container_parser_top.sv
// Texture container parser top level: one container byte per transfer in,
// header, frame duration, payload and status records out. A byte is taken
// every cycle while the record queue has room and the front is in its run
// state. Input stalls after the byte that completes the header for two
// registered multiply steps for the plane size, then the header check, and
// after the last byte of a file while the status record is queued. Results
// leave through a queue of QUEUE_DEPTH records and an output register.
// Depends on tcp_pkg, tcp_front, tcp_fifo and tcp_back.
module texture_container_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [12:0] out_width,
  output logic [12:0] out_height,
  output logic [8:0]  out_frames,
  output logic        out_with_normals,
  output logic [1:0]  out_format_version,
  output logic [63:0] out_source_time,
  output logic [31:0] out_source_size,
  output logic [15:0] out_duration_ms,
  output logic [7:0]  out_texel_byte,
  output logic        out_normal_plane,
  output logic [3:0]  out_status
);

  localparam int REC_W = $bits(tcp_pkg::rec_t);

  logic          q_push, q_full, q_pop, q_valid;
  tcp_pkg::rec_t push_rec, pop_rec;
  logic [REC_W-1:0] push_vec, pop_vec;

  assign push_vec = push_rec;
  assign pop_rec  = tcp_pkg::rec_t'(pop_vec);

  // Parse front
  tcp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_push       (q_push),
    .q_rec        (push_rec),
    .q_full       (q_full)
  );

  // Record queue
  tcp_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_vec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_vec),
    .valid     (q_valid)
  );

  // Output back end
  tcp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .q_valid            (q_valid),
    .q_rec              (pop_rec),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_width          (out_width),
    .out_height         (out_height),
    .out_frames         (out_frames),
    .out_with_normals   (out_with_normals),
    .out_format_version (out_format_version),
    .out_source_time    (out_source_time),
    .out_source_size    (out_source_size),
    .out_duration_ms    (out_duration_ms),
    .out_texel_byte     (out_texel_byte),
    .out_normal_plane   (out_normal_plane),
    .out_status         (out_status)
  );

endmodule

### hw/rtl/tcp_fifo.sv
// Texture container parser: small record queue between front and back.
// Show-ahead register FIFO, power-of-two depth. No package dependency.
module tcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;

  // Occupancy flags from wrap-bit pointers
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign valid = (wr_ptr_r != rd_ptr_r);
  assign pop_data = mem_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = (push && !full) ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = (pop && valid)  ? rd_ptr_r + 1'b1 : rd_ptr_r;

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

endmodule

### hw/rtl/tcp_front.sv
// Texture container parser: parse front end.
// Captures the header, runs the header checks and size product, classifies
// table and payload bytes and queues result records. Uses tcp_pkg.
module tcp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          q_push,
  output tcp_pkg::rec_t q_rec,
  input  logic          q_full
);

  typedef enum logic [4:0] {
    S_RUN  = 5'b00001,
    S_MUL1 = 5'b00010,
    S_MUL2 = 5'b00100,
    S_CHK  = 5'b01000,
    S_STAT = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic [287:0] hdr_r, hdr_nxt;
  logic [5:0]   hlen_r, hlen_nxt;
  logic [5:0]   hs_r, hs_nxt;
  logic [1:0]   ver_r, ver_nxt;
  logic         head_done_r, head_done_nxt;
  logic [3:0]   err_r, err_nxt;
  logic [32:0]  cnt_r, cnt_nxt;
  logic [9:0]   tbl_cnt_r, tbl_cnt_nxt;
  logic [31:0]  pay_idx_r, pay_idx_nxt;
  logic [7:0]   dlow_r, dlow_nxt;
  logic [8:0]   fc_r, fc_nxt;
  logic [31:0]  plane_r, plane_nxt;
  logic [31:0]  pay_len_r, pay_len_nxt;
  logic         dur_pend_r, dur_pend_nxt;
  logic         last_pend_r, last_pend_nxt;
  logic [25:0]  wh_r, wh_nxt;
  logic [34:0]  alb_r, alb_nxt;

  logic         acc;
  logic [5:0]   hl_inc;
  logic         to_check;

  // Header fields
  logic [31:0] h_magic, h_pay, h_ssize;
  logic [15:0] h_ver, h_hsize, h_w, h_h, h_fc, h_ms, h_fmt, h_res;
  logic [63:0] h_stime;

  assign h_magic = hdr_r[8*tcp_pkg::OFF_MAGIC  +: 32];
  assign h_ver   = hdr_r[8*tcp_pkg::OFF_VER    +: 16];
  assign h_hsize = hdr_r[8*tcp_pkg::OFF_HSIZE  +: 16];
  assign h_w     = hdr_r[8*tcp_pkg::OFF_WIDTH  +: 16];
  assign h_h     = hdr_r[8*tcp_pkg::OFF_HEIGHT +: 16];
  assign h_fc    = hdr_r[8*tcp_pkg::OFF_FRAMES +: 16];
  assign h_ms    = hdr_r[8*tcp_pkg::OFF_MS     +: 16];
  assign h_fmt   = hdr_r[8*tcp_pkg::OFF_FMT    +: 16];
  assign h_res   = hdr_r[8*tcp_pkg::OFF_RES    +: 16];
  assign h_pay   = hdr_r[8*tcp_pkg::OFF_PAY    +: 32];
  assign h_stime = hdr_r[8*tcp_pkg::OFF_STIME  +: 64];
  assign h_ssize = hdr_r[8*tcp_pkg::OFF_SSIZE  +: 32];

  assign in_ready = (state_r == S_RUN) && !q_full;
  assign acc      = in_valid && in_ready;

  // Table length in bytes and expected file length
  logic [9:0]  tbl_bytes;
  logic [32:0] total_len;
  logic [3:0]  stat_code;
  logic [15:0] tbl_word;

  assign tbl_bytes = (ver_r == 2'd1) ? 10'd0 : {fc_r, 1'b0};
  assign total_len = 33'(hs_r) + 33'(tbl_bytes) + 33'(pay_len_r);
  assign tbl_word  = {in_data_byte, dlow_r};

  always_comb begin
    if (err_r != tcp_pkg::ST_OK) begin
      stat_code = err_r;
    end else if (!head_done_r || cnt_r != total_len) begin
      stat_code = tcp_pkg::ST_LENGTH;
    end else if (dur_pend_r) begin
      stat_code = tcp_pkg::ST_DURATION;
    end else begin
      stat_code = tcp_pkg::ST_OK;
    end
  end

  // Full header check, in priority order
  logic        normals;
  logic [36:0] alb4;
  logic [37:0] expected;
  logic [3:0]  chk_err;

  assign normals  = (h_fmt == tcp_pkg::FMT_NORMALS);
  assign alb4     = {alb_r, 2'b00};
  assign expected = normals ? {alb4, 1'b0} : {1'b0, alb4};

  always_comb begin
    if ((!normals && h_fmt != tcp_pkg::FMT_ALBEDO) || h_res != 16'd0) begin
      chk_err = tcp_pkg::ST_FORMAT;
    end else if (h_w == 16'd0 || h_h == 16'd0 ||
                 h_w > tcp_pkg::MAX_DIMENSION || h_h > tcp_pkg::MAX_DIMENSION) begin
      chk_err = tcp_pkg::ST_DIMS;
    end else if (h_fc == 16'd0 || h_fc > tcp_pkg::MAX_FRAMES) begin
      chk_err = tcp_pkg::ST_FRAMES;
    end else if (h_fc > 16'd1 && h_ms == 16'd0) begin
      chk_err = tcp_pkg::ST_DURATION;
    end else if ({6'd0, h_pay} != expected) begin
      chk_err = tcp_pkg::ST_PAYSIZE;
    end else begin
      chk_err = tcp_pkg::ST_OK;
    end
  end

  // Sequencer and parse state
  always_comb begin
    state_nxt     = state_r;
    hdr_nxt       = hdr_r;
    hlen_nxt      = hlen_r;
    hs_nxt        = hs_r;
    ver_nxt       = ver_r;
    head_done_nxt = head_done_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    tbl_cnt_nxt   = tbl_cnt_r;
    pay_idx_nxt   = pay_idx_r;
    dlow_nxt      = dlow_r;
    fc_nxt        = fc_r;
    plane_nxt     = plane_r;
    pay_len_nxt   = pay_len_r;
    dur_pend_nxt  = dur_pend_r;
    last_pend_nxt = last_pend_r;
    wh_nxt        = wh_r;
    alb_nxt       = alb_r;
    to_check      = 1'b0;
    hl_inc        = (hlen_r < tcp_pkg::HEADER_V2_BYTES) ? hlen_r + 6'd1 : hlen_r;
    q_push        = 1'b0;

    q_rec.kind         = tcp_pkg::KIND_PAYLOAD;
    q_rec.width        = h_w[12:0];
    q_rec.height       = h_h[12:0];
    q_rec.frames       = h_fc[8:0];
    q_rec.with_normals = normals;
    q_rec.version      = ver_r;
    q_rec.source_time  = (ver_r == 2'd1) ? 64'd0 : h_stime;
    q_rec.source_size  = (ver_r == 2'd1) ? 32'd0 : h_ssize;
    q_rec.duration     = (fc_r > 9'd1) ? tbl_word : 16'd0;
    q_rec.texel        = in_data_byte;
    q_rec.normal_plane = (pay_idx_r >= plane_r);
    q_rec.status       = stat_code;

    case (state_r)
      S_RUN: begin
        if (acc) begin
          cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + 33'd1;
          if (err_r == tcp_pkg::ST_OK) begin
            if (!head_done_r) begin
              // Header capture
              if (hlen_r < tcp_pkg::HEADER_V2_BYTES) begin
                hdr_nxt[{hlen_r, 3'b000} +: 8] = in_data_byte;
              end
              hlen_nxt = hl_inc;
              // Magic and version once the short header is in
              if (hl_inc == tcp_pkg::HEADER_V1_BYTES && hs_r == 6'd0) begin
                if (h_magic != tcp_pkg::MAGIC_WORD) begin
                  err_nxt = tcp_pkg::ST_MAGIC;
                end else if (h_ver == tcp_pkg::VERSION_ONE &&
                             h_hsize == 16'(tcp_pkg::HEADER_V1_BYTES)) begin
                  hs_nxt = tcp_pkg::HEADER_V1_BYTES;
                end else if (h_ver == tcp_pkg::CURRENT_VERSION &&
                             h_hsize == 16'(tcp_pkg::HEADER_V2_BYTES)) begin
                  hs_nxt = tcp_pkg::HEADER_V2_BYTES;
                end else begin
                  err_nxt = tcp_pkg::ST_VERSION;
                end
                ver_nxt = (h_ver == tcp_pkg::VERSION_ONE) ? 2'd1 : 2'd2;
              end
              to_check = (err_nxt == tcp_pkg::ST_OK) && (hs_nxt != 6'd0) &&
                         (hl_inc == hs_nxt);
            end else if (tbl_cnt_r < tbl_bytes) begin
              // Frame duration table
              tbl_cnt_nxt = tbl_cnt_r + 10'd1;
              if (!tbl_cnt_r[0]) begin
                dlow_nxt = in_data_byte;
              end else begin
                if (fc_r > 9'd1 && tbl_word == 16'd0) begin
                  dur_pend_nxt = 1'b1;
                end
                q_rec.kind = tcp_pkg::KIND_DURATION;
                q_push     = 1'b1;
              end
            end else if (pay_idx_r >= pay_len_r) begin
              // Byte beyond the payload
              err_nxt = tcp_pkg::ST_LENGTH;
            end else begin
              pay_idx_nxt = pay_idx_r + 32'd1;
              q_rec.kind  = tcp_pkg::KIND_PAYLOAD;
              q_push      = 1'b1;
            end
          end
          if (to_check) begin
            state_nxt     = S_MUL1;
            last_pend_nxt = in_last_byte;
          end else if (in_last_byte) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_MUL1: begin
        wh_nxt    = h_w[12:0] * h_h[12:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        alb_nxt   = wh_r * h_fc[8:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        q_rec.kind     = tcp_pkg::KIND_HEADER;
        q_rec.duration = (h_fc > 16'd1) ? h_ms : 16'd0;
        if (chk_err != tcp_pkg::ST_OK) begin
          err_nxt   = chk_err;
          state_nxt = last_pend_r ? S_STAT : S_RUN;
        end else if (!q_full) begin
          q_push        = 1'b1;
          head_done_nxt = 1'b1;
          fc_nxt        = h_fc[8:0];
          plane_nxt     = alb4[31:0];
          pay_len_nxt   = h_pay;
          tbl_cnt_nxt   = 10'd0;
          pay_idx_nxt   = 32'd0;
          state_nxt     = last_pend_r ? S_STAT : S_RUN;
        end
      end
      S_STAT: begin
        q_rec.kind = tcp_pkg::KIND_STATUS;
        if (!q_full) begin
          // Final status, then back to a clean parse state
          q_push        = 1'b1;
          hlen_nxt      = 6'd0;
          hs_nxt        = 6'd0;
          ver_nxt       = 2'd0;
          head_done_nxt = 1'b0;
          err_nxt       = tcp_pkg::ST_OK;
          cnt_nxt       = 33'd0;
          tbl_cnt_nxt   = 10'd0;
          pay_idx_nxt   = 32'd0;
          dlow_nxt      = 8'd0;
          fc_nxt        = 9'd0;
          plane_nxt     = 32'd0;
          pay_len_nxt   = 32'd0;
          dur_pend_nxt  = 1'b0;
          last_pend_nxt = 1'b0;
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      hlen_r      <= '0;
      hs_r        <= '0;
      ver_r       <= '0;
      head_done_r <= 1'b0;
      err_r       <= tcp_pkg::ST_OK;
      cnt_r       <= '0;
      tbl_cnt_r   <= '0;
      pay_idx_r   <= '0;
      dlow_r      <= '0;
      fc_r        <= '0;
      plane_r     <= '0;
      pay_len_r   <= '0;
      dur_pend_r  <= 1'b0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hlen_r      <= hlen_nxt;
      hs_r        <= hs_nxt;
      ver_r       <= ver_nxt;
      head_done_r <= head_done_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      tbl_cnt_r   <= tbl_cnt_nxt;
      pay_idx_r   <= pay_idx_nxt;
      dlow_r      <= dlow_nxt;
      fc_r        <= fc_nxt;
      plane_r     <= plane_nxt;
      pay_len_r   <= pay_len_nxt;
      dur_pend_r  <= dur_pend_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  // Header bytes and size products
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    wh_r  <= wh_nxt;
    alb_r <= alb_nxt;
  end

  // Only the first error is kept until the status goes out
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != tcp_pkg::ST_OK && state_r != S_STAT) |=> err_r == $past(err_r))
    else $error("error code changed before status");

  // Header is accepted only by the check step
  a_head_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(head_done_r) |-> $past(state_r) == S_CHK)
    else $error("header done set outside check");

  // Never push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push while queue full");

  // Payload index stays within the declared payload
  a_pay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_done_r |-> pay_idx_r <= pay_len_r)
    else $error("payload index beyond payload length");

endmodule

### hw/rtl/tcp_back.sv
// Texture container parser: output back end.
// Holds want_normals, drops filtered normal bytes, zero-fills fields not
// owned by the record kind and drives the output register. Uses tcp_pkg.
module tcp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          q_valid,
  input  tcp_pkg::rec_t q_rec,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [12:0]   out_width,
  output logic [12:0]   out_height,
  output logic [8:0]    out_frames,
  output logic          out_with_normals,
  output logic [1:0]    out_format_version,
  output logic [63:0]   out_source_time,
  output logic [31:0]   out_source_size,
  output logic [15:0]   out_duration_ms,
  output logic [7:0]    out_texel_byte,
  output logic          out_normal_plane,
  output logic [3:0]    out_status
);

  logic          want_r;
  logic          ov_r, ov_nxt;
  logic          drop;
  logic          load;
  logic          is_hdr, is_dur, is_pay, is_stat;
  tcp_pkg::rec_t rec_r, rec_nxt;

  assign is_hdr  = (q_rec.kind == tcp_pkg::KIND_HEADER);
  assign is_dur  = (q_rec.kind == tcp_pkg::KIND_DURATION);
  assign is_pay  = (q_rec.kind == tcp_pkg::KIND_PAYLOAD);
  assign is_stat = (q_rec.kind == tcp_pkg::KIND_STATUS);

  // Pop when the output register is free or being emptied
  assign drop  = is_pay && q_rec.normal_plane && !want_r;
  assign q_pop = q_valid && (!ov_r || out_ready);
  assign load  = q_pop && !drop;
  assign ov_nxt = load ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  // Zero fields that the record kind does not own
  always_comb begin
    rec_nxt              = '0;
    rec_nxt.kind         = q_rec.kind;
    if (is_hdr) begin
      rec_nxt.width        = q_rec.width;
      rec_nxt.height       = q_rec.height;
      rec_nxt.frames       = q_rec.frames;
      rec_nxt.with_normals = q_rec.with_normals;
      rec_nxt.version      = q_rec.version;
      rec_nxt.source_time  = q_rec.source_time;
      rec_nxt.source_size  = q_rec.source_size;
    end
    if (is_hdr || is_dur) begin
      rec_nxt.duration = q_rec.duration;
    end
    if (is_pay) begin
      rec_nxt.texel        = q_rec.texel;
      rec_nxt.normal_plane = q_rec.normal_plane;
    end
    if (is_stat) begin
      rec_nxt.status = q_rec.status;
    end
  end

  // Config register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_r <= 1'b1;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        want_r <= cfg_wdata;
      end
      ov_r <= ov_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = rec_r.kind;
  assign out_width          = rec_r.width;
  assign out_height         = rec_r.height;
  assign out_frames         = rec_r.frames;
  assign out_with_normals   = rec_r.with_normals;
  assign out_format_version = rec_r.version;
  assign out_source_time    = rec_r.source_time;
  assign out_source_size    = rec_r.source_size;
  assign out_duration_ms    = rec_r.duration;
  assign out_texel_byte     = rec_r.texel;
  assign out_normal_plane   = rec_r.normal_plane;
  assign out_status         = rec_r.status;

endmodule
